[design/lmc_pkg.sv]
// ----------------------------------------------------------------------------
// lmc_pkg: shared types and constants for the logger mode controller
// Mode encoding, register indexes, reset values and the action pulse bundle.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_LOGGING  = 3'd2,
        MODE_FAULT    = 3'd3,
        MODE_SHUTDOWN = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_SHUTDOWN_TIMEOUT = 2'd0,
        CFG_SILENCE_TIMEOUT       = 2'd1
    } cfg_index_t;

    localparam logic [TIME_W-1:0] IDLE_SHUTDOWN_TIMEOUT_RST = 32'd300000;
    localparam logic [TIME_W-1:0] SILENCE_TIMEOUT_RST       = 32'd2500;

    // One-tick action pulses that go with each result
    typedef struct packed {
        logic open_session;
        logic close_session;
        logic retry_mount;
        logic flush_buffers;
        logic unmount_card;
    } actions_t;

endpackage

[design/logger_mode_controller.sv]
// ----------------------------------------------------------------------------
// logger_mode_controller: tick-driven mode controller for a data logger
// Tracks init/idle/logging/fault/shutdown, frame silence and shutdown actions.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_valid / s_ready    one tick: time, card, periph, frame
//  m_        out        m_valid / m_ready    new mode, action pulses, card fault
//  cfg_      in         cfg_valid/cfg_ready  register index and write data
//
//  Each tick transaction is accepted into the input register, then passes
//  the mode logic into the result register, where m_valid rises; one tick
//  can be accepted every cycle while m_ready does not stall the result.
//  The only loop is the mode/timestamp update, one subtract-and-compare deep,
//  which is closed through the controller state registers.
//  Reset (aresetn low, synchronous) returns to init mode with the default
//  timeouts. A stall on m_ready holds the result register and, through the
//  input register, s_ready; cfg_ready is always high.
//
module logger_mode_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tick input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lmc_pkg::TIME_W-1:0]          s_now_ms,
    input  logic                                s_card_mounted,
    input  logic                                s_periph_ready,
    input  logic                                s_frame_seen,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_mode,
    output logic                                m_open_session,
    output logic                                m_close_session,
    output logic                                m_retry_mount,
    output logic                                m_flush_buffers,
    output logic                                m_unmount_card,
    output logic                                m_card_fault,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lmc_pkg::TIME_W-1:0]          cfg_data
);

    // Configuration registers
    logic [lmc_pkg::TIME_W-1:0] idle_timeout_reg;
    logic [lmc_pkg::TIME_W-1:0] silence_timeout_reg;

    // Input register
    logic                       in_valid_reg;
    logic [lmc_pkg::TIME_W-1:0] in_now_reg;
    logic                       in_card_reg;
    logic                       in_periph_reg;
    logic                       in_frame_reg;

    // Controller state
    lmc_pkg::mode_t             mode_reg;
    logic [lmc_pkg::TIME_W-1:0] last_frame_reg;
    logic                       shutdown_done_reg;
    logic                       card_fault_reg;

    // Result register
    logic                       out_valid_reg;
    lmc_pkg::mode_t             out_mode_reg;
    lmc_pkg::actions_t          out_actions_reg;
    logic                       out_card_fault_reg;

    // Step logic outputs
    lmc_pkg::mode_t             mode_next;
    logic [lmc_pkg::TIME_W-1:0] last_frame_next;
    logic                       shutdown_done_next;
    logic                       card_fault_next;
    lmc_pkg::actions_t          actions_next;

    logic                       advance;
    logic                       s_fire;

    // Move a tick from input to result when the result slot is free or leaving
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    lmc_step u_step (
        .mode                  (mode_reg),
        .last_frame_time       (last_frame_reg),
        .shutdown_done         (shutdown_done_reg),
        .card_fault_latched    (card_fault_reg),
        .idle_shutdown_timeout (idle_timeout_reg),
        .silence_timeout       (silence_timeout_reg),
        .now_ms                (in_now_reg),
        .card_mounted          (in_card_reg),
        .periph_ready          (in_periph_reg),
        .frame_seen            (in_frame_reg),
        .mode_next             (mode_next),
        .last_frame_time_next  (last_frame_next),
        .shutdown_done_next    (shutdown_done_next),
        .card_fault_next       (card_fault_next),
        .actions               (actions_next)
    );

    // Configuration: unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg    <= lmc_pkg::IDLE_SHUTDOWN_TIMEOUT_RST;
            silence_timeout_reg <= lmc_pkg::SILENCE_TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lmc_pkg::CFG_IDLE_SHUTDOWN_TIMEOUT: idle_timeout_reg    <= cfg_data;
                lmc_pkg::CFG_SILENCE_TIMEOUT:       silence_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload: load only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_now_reg    <= s_now_ms;
            in_card_reg   <= s_card_mounted;
            in_periph_reg <= s_periph_ready;
            in_frame_reg  <= s_frame_seen;
        end
    end

    // Controller state: advance once per tick that reaches the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= lmc_pkg::MODE_INIT;
            last_frame_reg    <= '0;
            shutdown_done_reg <= 1'b0;
            card_fault_reg    <= 1'b0;
        end else if (advance) begin
            mode_reg          <= mode_next;
            last_frame_reg    <= last_frame_next;
            shutdown_done_reg <= shutdown_done_next;
            card_fault_reg    <= card_fault_next;
        end
    end

    // Result register control: hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mode_reg       <= mode_next;
            out_actions_reg    <= actions_next;
            out_card_fault_reg <= card_fault_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_mode          = out_mode_reg;
    assign m_open_session  = out_actions_reg.open_session;
    assign m_close_session = out_actions_reg.close_session;
    assign m_retry_mount   = out_actions_reg.retry_mount;
    assign m_flush_buffers = out_actions_reg.flush_buffers;
    assign m_unmount_card  = out_actions_reg.unmount_card;
    assign m_card_fault    = out_card_fault_reg;

endmodule

[design/lmc_step.sv]
// ----------------------------------------------------------------------------
// lmc_step: mode transition logic for one controller tick
// Computes the next mode, next frame timestamp, sticky flags and pulses.
// ----------------------------------------------------------------------------
module lmc_step (
    input  logic [2:0]                  mode,
    input  logic [lmc_pkg::TIME_W-1:0]  last_frame_time,
    input  logic                        shutdown_done,
    input  logic                        card_fault_latched,
    input  logic [lmc_pkg::TIME_W-1:0]  idle_shutdown_timeout,
    input  logic [lmc_pkg::TIME_W-1:0]  silence_timeout,
    input  logic [lmc_pkg::TIME_W-1:0]  now_ms,
    input  logic                        card_mounted,
    input  logic                        periph_ready,
    input  logic                        frame_seen,
    output lmc_pkg::mode_t              mode_next,
    output logic [lmc_pkg::TIME_W-1:0]  last_frame_time_next,
    output logic                        shutdown_done_next,
    output logic                        card_fault_next,
    output lmc_pkg::actions_t           actions
);

    logic [lmc_pkg::TIME_W-1:0] elapsed;
    logic                       idle_expired;
    logic                       silence_expired;

    // Modulo 2^32 difference, so a wrapped clock still measures correctly
    assign elapsed         = now_ms - last_frame_time;
    assign idle_expired    = (elapsed >= idle_shutdown_timeout);
    assign silence_expired = (elapsed >= silence_timeout);

    always_comb begin
        mode_next            = lmc_pkg::mode_t'(mode);
        last_frame_time_next = last_frame_time;
        shutdown_done_next   = shutdown_done;
        card_fault_next      = card_fault_latched;
        actions              = '0;

        unique case (mode)
            lmc_pkg::MODE_INIT: begin
                if (card_mounted && periph_ready) begin
                    mode_next = lmc_pkg::MODE_IDLE;
                end else if (!card_mounted) begin
                    card_fault_next = 1'b1;
                    mode_next       = lmc_pkg::MODE_FAULT;
                end
            end
            lmc_pkg::MODE_IDLE: begin
                if (frame_seen) begin
                    mode_next            = lmc_pkg::MODE_LOGGING;
                    actions.open_session = 1'b1;
                    last_frame_time_next = now_ms;
                end else if (idle_expired) begin
                    mode_next = lmc_pkg::MODE_SHUTDOWN;
                end
            end
            lmc_pkg::MODE_LOGGING: begin
                if (frame_seen) begin
                    last_frame_time_next = now_ms;
                end else if (silence_expired) begin
                    actions.close_session = 1'b1;
                    mode_next             = lmc_pkg::MODE_IDLE;
                end
            end
            lmc_pkg::MODE_FAULT: begin
                actions.retry_mount = 1'b1;
                // Timeout outranks recovery
                if (idle_expired) begin
                    mode_next = lmc_pkg::MODE_SHUTDOWN;
                end else if (card_mounted) begin
                    mode_next = lmc_pkg::MODE_IDLE;
                end
            end
            lmc_pkg::MODE_SHUTDOWN: begin
                if (!shutdown_done) begin
                    actions.flush_buffers = 1'b1;
                    actions.close_session = 1'b1;
                    actions.unmount_card  = 1'b1;
                    shutdown_done_next    = 1'b1;
                end
            end
            default: begin
                mode_next = lmc_pkg::MODE_FAULT;
            end
        endcase
    end

endmodule

[test/tb_logger_mode_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_logger_mode_controller: self-checking bench for the logger mode controller
// Drives controller ticks through a bursty valid/ready driver, predicts every
// result with a cycle-free model of the mode logic, and compares each result
// field by field while the result channel stalls on its own pattern. Timeout
// registers are rewritten between phases, once the controller is quiet.
// ----------------------------------------------------------------------------
module tb_logger_mode_controller;

    localparam int CYCLE_LIMIT = 200000;

    // Register indexes the controller does not decode
    localparam logic [lmc_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [lmc_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    typedef struct packed {
        logic [lmc_pkg::TIME_W-1:0] now_ms;
        logic                       card_mounted;
        logic                       periph_ready;
        logic                       frame_seen;
    } tick_t;

    typedef struct packed {
        logic [2:0]        mode;
        lmc_pkg::actions_t act;
        logic              card_fault;
    } mode_result_t;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic [lmc_pkg::TIME_W-1:0]      s_now_ms        = '0;
    logic                            s_card_mounted  = 1'b0;
    logic                            s_periph_ready  = 1'b0;
    logic                            s_frame_seen    = 1'b0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic [2:0]                      m_mode;
    logic                            m_open_session;
    logic                            m_close_session;
    logic                            m_retry_mount;
    logic                            m_flush_buffers;
    logic                            m_unmount_card;
    logic                            m_card_fault;
    logic                            cfg_valid       = 1'b0;
    logic                            cfg_ready;
    logic [lmc_pkg::CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [lmc_pkg::TIME_W-1:0]      cfg_data        = '0;

    always #5 aclk = ~aclk;

    logger_mode_controller u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_ms        (s_now_ms),
        .s_card_mounted  (s_card_mounted),
        .s_periph_ready  (s_periph_ready),
        .s_frame_seen    (s_frame_seen),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mode          (m_mode),
        .m_open_session  (m_open_session),
        .m_close_session (m_close_session),
        .m_retry_mount   (m_retry_mount),
        .m_flush_buffers (m_flush_buffers),
        .m_unmount_card  (m_unmount_card),
        .m_card_fault    (m_card_fault),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Mode predictor: private copy of controller state and timeouts
    // ------------------------------------------------------------------
    lmc_pkg::mode_t             mode_q          = lmc_pkg::MODE_INIT;
    logic [lmc_pkg::TIME_W-1:0] last_frame_q    = '0;
    logic                       shutdown_done_q = 1'b0;
    logic                       card_fault_q    = 1'b0;
    logic [lmc_pkg::TIME_W-1:0] idle_to_cfg     = lmc_pkg::IDLE_SHUTDOWN_TIMEOUT_RST;
    logic [lmc_pkg::TIME_W-1:0] silence_to_cfg  = lmc_pkg::SILENCE_TIMEOUT_RST;

    tick_t        tick_q[$];          // ticks waiting for the driver
    mode_result_t mode_expect_q[$];   // predicted results, oldest first

    int issued_cnt   = 0;
    int result_cnt   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    // Advance the predictor by one tick and return the result it produces
    function automatic mode_result_t step_mode(logic [lmc_pkg::TIME_W-1:0] now_ms,
                                               logic card, logic periph, logic frame);
        mode_result_t               r;
        logic [lmc_pkg::TIME_W-1:0] elapsed;
        lmc_pkg::mode_t             nxt;
        r       = '0;
        elapsed = now_ms - last_frame_q;   // modulo 2^32 by width
        nxt     = mode_q;
        case (mode_q)
            lmc_pkg::MODE_INIT: begin
                if (card && periph) begin
                    nxt = lmc_pkg::MODE_IDLE;
                end else if (!card) begin
                    card_fault_q = 1'b1;
                    nxt = lmc_pkg::MODE_FAULT;
                end
            end
            lmc_pkg::MODE_IDLE: begin
                if (frame) begin
                    nxt = lmc_pkg::MODE_LOGGING;
                    r.act.open_session = 1'b1;
                    last_frame_q = now_ms;
                end else if (elapsed >= idle_to_cfg) begin
                    nxt = lmc_pkg::MODE_SHUTDOWN;
                end
            end
            lmc_pkg::MODE_LOGGING: begin
                if (frame) begin
                    last_frame_q = now_ms;
                end else if (elapsed >= silence_to_cfg) begin
                    r.act.close_session = 1'b1;
                    nxt = lmc_pkg::MODE_IDLE;
                end
            end
            lmc_pkg::MODE_FAULT: begin
                // Timeout beats a remounted card
                r.act.retry_mount = 1'b1;
                if (card)
                    nxt = lmc_pkg::MODE_IDLE;
                if (elapsed >= idle_to_cfg)
                    nxt = lmc_pkg::MODE_SHUTDOWN;
            end
            lmc_pkg::MODE_SHUTDOWN: begin
                if (!shutdown_done_q) begin
                    r.act.flush_buffers = 1'b1;
                    r.act.close_session = 1'b1;
                    r.act.unmount_card  = 1'b1;
                    shutdown_done_q     = 1'b1;
                end
            end
            default: nxt = lmc_pkg::MODE_FAULT;
        endcase
        mode_q       = nxt;
        r.mode       = nxt;
        r.card_fault = card_fault_q;
        return r;
    endfunction

    function automatic void apply_cfg(logic [lmc_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [lmc_pkg::TIME_W-1:0] val);
        case (idx)
            lmc_pkg::CFG_IDLE_SHUTDOWN_TIMEOUT: idle_to_cfg    = val;
            lmc_pkg::CFG_SILENCE_TIMEOUT:       silence_to_cfg = val;
            default: ;                 // undecoded index: drop the write
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch on %s at result %0d: expected %0h, got %0h",
                         name, result_cnt, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Tick driver: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    int    burst_left = 1;
    int    gap_left   = 0;
    tick_t drv_tick;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end else begin
            // Predict at acceptance, with the payload that was on the port
            if (s_valid && s_ready)
                mode_expect_q.push_back(step_mode(s_now_ms, s_card_mounted,
                                                  s_periph_ready, s_frame_seen));
            // Hold the payload while a transaction is pending, else move on
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    drv_tick = tick_q.pop_front();
                    issued_cnt++;
                    s_now_ms       <= drv_tick.now_ms;
                    s_card_mounted <= drv_tick.card_mounted;
                    s_periph_ready <= drv_tick.periph_ready;
                    s_frame_seen   <= drv_tick.frame_seen;
                    s_valid        <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: free-running stall pattern, a quarter of it with
    // no stalls, a quarter with heavy stalls
    // ------------------------------------------------------------------
    logic [7:0] rdy_phase = '0;

    always @(posedge aclk) begin
        rdy_phase <= rdy_phase + 8'd1;
        case (rdy_phase[7:6])
            2'b00:   m_ready <= 1'b1;
            2'b11:   m_ready <= ($urandom_range(0, 9) < 3);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest prediction
    // ------------------------------------------------------------------
    mode_result_t mon_exp;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_cnt++;
            if (mode_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result %0d: mode %0d", result_cnt, m_mode);
            end else begin
                mon_exp = mode_expect_q.pop_front();
                check_field("mode",          32'(mon_exp.mode),              32'(m_mode));
                check_field("open_session",  32'(mon_exp.act.open_session),
                            32'(m_open_session));
                check_field("close_session", 32'(mon_exp.act.close_session),
                            32'(m_close_session));
                check_field("retry_mount",   32'(mon_exp.act.retry_mount),
                            32'(m_retry_mount));
                check_field("flush_buffers", 32'(mon_exp.act.flush_buffers),
                            32'(m_flush_buffers));
                check_field("unmount_card",  32'(mon_exp.act.unmount_card),
                            32'(m_unmount_card));
                check_field("card_fault",    32'(mon_exp.card_fault),        32'(m_card_fault));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    logic [lmc_pkg::TIME_W-1:0] gen_now        = '0;
    logic [lmc_pkg::TIME_W-1:0] gen_last_frame = '0;  // tracks last_frame_q out of init/fault
    logic                       gen_prev_frame = 1'b0;

    task automatic add_tick(input logic [lmc_pkg::TIME_W-1:0] now_ms, input logic card,
                            input logic periph, input logic frame);
        tick_t t;
        t.now_ms       = now_ms;
        t.card_mounted = card;
        t.periph_ready = periph;
        t.frame_seen   = frame;
        tick_q.push_back(t);
    endtask

    // Random ticks from idle/logging. Times mostly creep forward, some sit on
    // the silence edge, a few jump anywhere. Before the last phase, never let
    // a frameless tick after a frameless tick reach the idle timeout: the
    // previous tick may have left idle behind, and shutdown is terminal.
    task automatic gen_ticks(input int count, input bit final_phase);
        tick_t                      t;
        int                         pick;
        logic [lmc_pkg::TIME_W-1:0] since;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                t.now_ms = $urandom();
            else if (pick < 30)
                t.now_ms = gen_last_frame + silence_to_cfg + $urandom_range(0, 2) - 1;
            else if (pick < 40)
                t.now_ms = gen_now;
            else
                t.now_ms = gen_now + $urandom_range(0, 400);
            t.card_mounted = 1'($urandom_range(0, 1));
            t.periph_ready = 1'($urandom_range(0, 1));
            t.frame_seen   = ($urandom_range(0, 9) < 4);
            since = t.now_ms - gen_last_frame;
            if (!final_phase && !gen_prev_frame && since >= idle_to_cfg)
                t.frame_seen = 1'b1;
            if (t.frame_seen)
                gen_last_frame = t.now_ms;
            gen_prev_frame = t.frame_seen;
            gen_now        = t.now_ms;
            tick_q.push_back(t);
        end
    endtask

    // Hold until every tick is out and every result is back
    task automatic wait_quiet();
        while (tick_q.size() != 0 || issued_cnt != result_cnt || mode_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Keep cfg_valid high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [lmc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lmc_pkg::TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_cfg(idx, val);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset timeouts (idle 300000, silence 2500)
        add_tick(32'd0,      1'b1, 1'b0, 1'b1);  // card up, periph not ready: init holds
        add_tick(32'd5,      1'b1, 1'b0, 1'b0);
        add_tick(32'd10,     1'b0, 1'b1, 1'b0);  // card missing: fault, latch card fault
        add_tick(32'd20,     1'b0, 1'b0, 1'b1);  // fault, retry mount
        add_tick(32'd299999, 1'b0, 1'b1, 1'b0);  // one below idle timeout
        add_tick(32'd30,     1'b1, 1'b0, 1'b0);  // card back: idle
        add_tick(32'd100,    1'b0, 1'b1, 1'b0);
        add_tick(32'd200,    1'b1, 1'b1, 1'b1);  // frame: open session
        add_tick(32'd2699,   1'b0, 1'b0, 1'b0);  // silence one short
        add_tick(32'd2700,   1'b1, 1'b0, 1'b1);
        add_tick(32'd5200,   1'b0, 1'b1, 1'b0);  // silence hit exactly: close
        add_tick(32'd302699, 1'b1, 1'b1, 1'b0);  // idle one short of shutdown
        add_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_tick(32'h0000_09C3, 1'b0, 1'b0, 1'b0);  // silence across the wrap
        add_tick(32'h8000_0000, 1'b1, 1'b0, 1'b1);
        add_tick(32'h8000_0001, 1'b0, 1'b1, 1'b1);
        gen_now        = 32'h8000_0001;
        gen_last_frame = 32'h8000_0001;
        gen_prev_frame = 1'b1;
        wait_quiet();

        // Idle timeout at its top, silence at 1; poke undecoded indexes
        write_reg(lmc_pkg::CFG_IDLE_SHUTDOWN_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(lmc_pkg::CFG_SILENCE_TIMEOUT, 32'd1);
        write_reg(CFG_IDX_SPARE2, $urandom());
        write_reg(CFG_IDX_SPARE3, 32'd0);
        cfg_valid <= 1'b0;
        gen_ticks(120, 1'b0);
        wait_quiet();

        write_reg(lmc_pkg::CFG_SILENCE_TIMEOUT, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        gen_ticks(120, 1'b0);
        wait_quiet();

        // Zero silence: logging closes on the first frameless tick
        write_reg(lmc_pkg::CFG_SILENCE_TIMEOUT, 32'd0);
        cfg_valid <= 1'b0;
        gen_ticks(100, 1'b0);
        wait_quiet();

        write_reg(lmc_pkg::CFG_SILENCE_TIMEOUT, $urandom_range(2, 3000));
        cfg_valid <= 1'b0;
        gen_ticks(120, 1'b0);
        wait_quiet();

        // Last phase: an idle timeout of 1 drives shutdown, actions fire once
        write_reg(lmc_pkg::CFG_IDLE_SHUTDOWN_TIMEOUT, 32'd1);
        cfg_valid <= 1'b0;
        gen_ticks(60, 1'b1);
        wait_quiet();

        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
design/lmc_pkg.sv
design/lmc_step.sv
design/logger_mode_controller.sv
test/tb_logger_mode_controller.sv
